// ----- rtl/core/kcdl_pkg.sv -----
package kcdl_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [TIME_W-1:0] TIME_WRAP = 16'hFFFF;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 16'd2000;
  localparam logic [TIME_W-1:0] DOUBLE_GAP_RESET = 16'd500;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_DOUBLE_GAP = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_SHORTREL = 3'd2,
    ST_WAITDBL  = 3'd3,
    ST_DBLPRESS = 3'd4,
    ST_LONG     = 3'd5
  } key_state_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } key_event_t;

  // elapsed time past a limit; a stamp ahead of now counts as past
  function automatic logic beyond(input logic [TIME_W-1:0] now,
                                  input logic [TIME_W-1:0] stamp,
                                  input logic [TIME_W-1:0] limit);
    logic [TIME_W-1:0] diff;
    diff = now - stamp;
    return (now < stamp) || (diff > limit);
  endfunction

endpackage

// ----- rtl/core/key_click_double_long_detector.sv -----
// channel | signals                              | direction | transaction
// in      | in_valid, in_ready, pin_level, now_ms | into      | one key sample
// out     | out_valid, out_ready, event_code,     | out of    | state after a sample
//         | fsm_state, debounced_pressed          |           |
// cfg     | cfg_valid, cfg_ready, cfg_index,      | into      | one register write
//         | cfg_data                              |           |
//
// one sample per cycle; its result appears the cycle after acceptance.
// the state registers are the result register: debounce compare, stamp update and
// the fsm step sit in one combinational pass in front of them.
// a stalled result holds the state; a new sample is taken in the cycle the result
// leaves, so throughput stays at one sample per cycle.
// reset clears the state, the stamps and loads the default limits; cfg is always ready.
module key_click_double_long_detector
  import kcdl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   pin_level,
  input  logic [TIME_W-1:0]      now_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             event_code,
  output logic [2:0]             fsm_state,
  output logic                   debounced_pressed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]      cfg_data
);

  logic [TIME_W-1:0] debounce_ms;
  logic [TIME_W-1:0] long_press_ms;
  logic [TIME_W-1:0] double_gap_ms;

  key_state_t        state, state_next;
  key_event_t        event_reg, event_reg_next;
  logic              pressed_flag, pressed_flag_next;
  logic [TIME_W-1:0] press_stamp, press_stamp_next;
  logic [TIME_W-1:0] release_stamp, release_stamp_next;

  logic              in_accept;
  logic              level;
  logic [TIME_W-1:0] now;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign level = !pin_level;
  assign now   = (now_ms == TIME_WRAP) ? '0 : now_ms;

  // debounce and stamp update
  always_comb begin
    pressed_flag_next  = pressed_flag;
    press_stamp_next   = press_stamp;
    release_stamp_next = release_stamp;
    if (level != pressed_flag && beyond(now, release_stamp, debounce_ms)) begin
      pressed_flag_next = level;
      if (level) begin
        press_stamp_next = now;
      end else begin
        release_stamp_next = now;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pressed_flag_next) state_next = ST_PRESSED;
      end
      ST_PRESSED: begin
        if (!pressed_flag_next) begin
          state_next = ST_SHORTREL;
        end else if (beyond(now, press_stamp_next, long_press_ms)) begin
          state_next = ST_LONG;
        end
      end
      ST_SHORTREL: state_next = ST_WAITDBL;
      ST_WAITDBL: begin
        if (pressed_flag_next) begin
          state_next = ST_DBLPRESS;
        end else if (beyond(now, release_stamp_next, double_gap_ms)) begin
          state_next = ST_IDLE;
        end
      end
      ST_DBLPRESS: begin
        if (!pressed_flag_next) state_next = ST_IDLE;
      end
      ST_LONG: begin
        if (!pressed_flag_next) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // event register
  always_comb begin
    event_reg_next = event_reg;
    unique case (state)
      ST_IDLE: event_reg_next = EV_NONE;
      ST_PRESSED: begin
        if (pressed_flag_next && beyond(now, press_stamp_next, long_press_ms)) begin
          event_reg_next = EV_LONG;
        end
      end
      ST_WAITDBL: begin
        if (!pressed_flag_next && beyond(now, release_stamp_next, double_gap_ms)) begin
          event_reg_next = EV_CLICK;
        end
      end
      ST_DBLPRESS: begin
        if (!pressed_flag_next) event_reg_next = EV_DOUBLE;
      end
      default: event_reg_next = event_reg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      event_reg     <= EV_NONE;
      pressed_flag  <= 1'b0;
      press_stamp   <= '0;
      release_stamp <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        state         <= state_next;
        event_reg     <= event_reg_next;
        pressed_flag  <= pressed_flag_next;
        press_stamp   <= press_stamp_next;
        release_stamp <= release_stamp_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RESET;
      long_press_ms <= LONG_PRESS_RESET;
      double_gap_ms <= DOUBLE_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_ms   <= cfg_data;
        REG_LONG_PRESS: long_press_ms <= cfg_data;
        REG_DOUBLE_GAP: double_gap_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign event_code        = event_reg;
  assign fsm_state         = state;
  assign debounced_pressed = pressed_flag;

  // a long press state always carries its event
  a_long_has_event: assert property (@(posedge clk) disable iff (rst)
    state == ST_LONG |-> event_reg == EV_LONG)
    else $error("long press state without long press event");

  // between leaving idle and the next event nothing is reported
  a_no_event_in_progress: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRESSED || state == ST_SHORTREL || state == ST_WAITDBL ||
     state == ST_DBLPRESS) |-> event_reg == EV_NONE)
    else $error("stale event during a click sequence");

  // held states only while the debounced key is down
  a_held_states_pressed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRESSED || state == ST_DBLPRESS) |-> pressed_flag)
    else $error("pressed state with key released");

  // a sample taken in idle clears the event
  a_idle_clears_event: assert property (@(posedge clk) disable iff (rst)
    (in_accept && state == ST_IDLE) |=> event_reg == EV_NONE)
    else $error("idle did not clear event");

endmodule
